>>> src/assert_macros.svh
// Assertion macros shared by the pulse train transmitter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTT_ASSERT(lbl, prop, msg)
`define PTT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/ptt_pkg.sv
// Shared types and constants for the pulse train transmitter.
// No dependencies; imported by every module of the block except ptt_ram.
package ptt_pkg;

  localparam int CHANNEL_COUNT    = 2;
  localparam int TOTAL_BLOCKS     = 4;
  localparam int WPB_DEFAULT      = 48;
  localparam int STORE_DEFAULT    = 192;
  localparam int IN_TDATA_W       = 48;
  localparam int OUT_TDATA_W      = 40;
  localparam int RESULT_W         = 39;

  // opcodes
  localparam logic [2:0] OP_REG_RD = 3'd0;
  localparam logic [2:0] OP_REG_WR = 3'd1;
  localparam logic [2:0] OP_RAM_RD = 3'd2;
  localparam logic [2:0] OP_RAM_WR = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // register map (byte offsets)
  localparam logic [9:0] REG_SETUP0  = 10'h010;
  localparam logic [9:0] REG_SETUP1  = 10'h014;
  localparam logic [9:0] REG_ADDR0   = 10'h028;
  localparam logic [9:0] REG_ADDR1   = 10'h02c;
  localparam logic [9:0] REG_IRQ_RAW = 10'h038;
  localparam logic [9:0] REG_IRQ_MSK = 10'h03c;
  localparam logic [9:0] REG_IRQ_EN  = 10'h040;
  localparam logic [9:0] REG_IRQ_CLR = 10'h044;
  localparam logic [9:0] REG_CARR0   = 10'h048;
  localparam logic [9:0] REG_CARR1   = 10'h04c;
  localparam logic [9:0] REG_THR0    = 10'h058;
  localparam logic [9:0] REG_THR1    = 10'h05c;
  localparam logic [9:0] REG_CLOCK   = 10'h068;

  localparam logic [22:0] SETUP_MASK  = 23'h7fff78;
  localparam logic [22:0] SETUP_RST   = 23'h710200;
  localparam logic [19:0] THR_RST     = 20'd128;
  localparam logic [31:0] CLOCK_RST   = 32'h05000010;
  localparam logic [31:0] CLOCK_MASK  = 32'h87ffffff;
  localparam logic [31:0] CLOCK_BAD   = 32'h00fff004;
  localparam logic [16:0] MIN_BASE    = 17'd125;
  localparam logic [16:0] MIN_FAST    = 17'd150;
  localparam logic [16:0] MIN_SLOW    = 17'd300;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_RAMRD, ST_START, ST_TICK,
    ST_ACHK, ST_ARD, ST_AMUL, ST_AFIN, ST_FIN
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic ramrd;
    logic start;
    logic tick;
    logic achk;
    logic ard;
    logic amul;
    logic afin;
    logic finish;
    logic ch;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       wr_ch;
    logic       start_ok;
    logic       tick_adv;
    logic       achk_stop;
    logic       ard_stop;
  } sts_t;

endpackage

>>> src/ptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ptt_datapath.sv
// Datapath: register file, channel state, symbol RAM, pulse timing math.
// Depends on ptt_pkg and ptt_ram; driven by ptt_ctrl commands.
module ptt_datapath import ptt_pkg::*; #(
  parameter int WORDS_PER_BLOCK = WPB_DEFAULT,
  parameter int STORE_WORDS     = STORE_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_op,
  input  logic [9:0]          in_addr,
  input  logic [31:0]         in_data,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic [RESULT_W-1:0] result
);

  localparam int POS_W = $clog2(2 * TOTAL_BLOCKS * WORDS_PER_BLOCK + 1);
  localparam int LIM_W = $clog2(14 * WORDS_PER_BLOCK + 1);
  localparam int AW    = $clog2(STORE_WORDS);

  logic [2:0]  op_r;
  logic [9:0]  addr_r;
  logic [31:0] data_r;
  logic [31:0] rd_r;

  logic [31:0] clk_setup_r;
  logic [13:0] irq_raw_r, irq_en_r;
  logic [22:0] setup_r [CHANNEL_COUNT];
  logic [22:0] app_setup_r [CHANNEL_COUNT];
  logic [19:0] thr_r [CHANNEL_COUNT];
  logic [19:0] app_thr_r [CHANNEL_COUNT];
  logic [POS_W-1:0] pos_r [CHANNEL_COUNT];
  logic [8:0]  sent_r [CHANNEL_COUNT];
  logic        busy_r [CHANNEL_COUNT];
  logic [31:0] held_r [CHANNEL_COUNT];
  logic [31:0] cyc_r [CHANNEL_COUNT];
  logic [31:0] carrier_r [CHANNEL_COUNT];
  logic        lvl_r [CHANNEL_COUNT];
  logic        en_r [CHANNEL_COUNT];
  logic [1:0]  faults_r;
  logic        start_pend_r;
  logic        fetch_r, fetch_ok_r;
  logic [15:0] pulse_r;
  logic [23:0] prod1_r;
  logic [32:0] cycles_r;
  logic [RESULT_W-1:0] result_r;

  logic        ch, oc, wr_ch;
  logic [22:0] new_s, s;
  logic        su_fault, busy_a, fault_any;
  logic [2:0]  blocks;
  logic [1:0]  src;
  logic        bad, overlap;
  logic [LIM_W-1:0] lim_pos;
  logic        at_end;
  logic [POS_W-1:0] pos_eff, pos_inc;
  logic [31:0] fidx, bidx;
  logic        bus_ok;
  logic [31:0] word;
  logic [15:0] pulse;
  logic [8:0]  divv, cdiv;
  logic [8:0]  lim, sent_inc;
  logic [38:0] t25, twons;
  logic [16:0] min_t;
  logic        too_short;
  logic [31:0] reg_rd;
  logic [31:0] ram_q;
  logic [1:0]  lv_v, en_v;

  assign ch    = cmd.ch;
  assign oc    = ~cmd.ch;
  assign wr_ch = addr_r[2];
  assign new_s = data_r[22:0] & SETUP_MASK;
  assign s     = app_setup_r[ch];
  assign blocks = s[18:16];
  assign src   = clk_setup_r[25:24];
  assign lim   = app_thr_r[ch][8:0];

  // setup write: update, stop, rewind, start
  assign su_fault  = data_r[24] && busy_r[wr_ch] && (app_setup_r[wr_ch] != new_s) &&
                     !data_r[7];
  assign busy_a    = busy_r[wr_ch] && !(data_r[24] && (su_fault || data_r[7]));
  assign fault_any = su_fault || (data_r[0] && busy_a);

  // start checks
  assign bad = (blocks == 3'd0) || (blocks > (ch ? 3'd3 : 3'd4)) || s[21] || s[3] ||
               app_thr_r[ch][19] || !clk_setup_r[26] || !clk_setup_r[0] ||
               ((clk_setup_r & CLOCK_BAD) != '0) || !((src == 2'd1) || (src == 2'd3));
  assign overlap = busy_r[oc] && ((!ch && (blocks > 3'd1)) ||
                   (ch && (app_setup_r[oc][18:16] > 3'd1)));

  // end of channel RAM and fetch address
  assign lim_pos = LIM_W'(blocks) * LIM_W'(2 * WORDS_PER_BLOCK);
  assign at_end  = LIM_W'(pos_r[ch]) >= lim_pos;
  assign pos_eff = at_end ? '0 : pos_r[ch];
  assign pos_inc = pos_r[ch] + 1'b1;
  assign fidx    = (ch ? 32'(WORDS_PER_BLOCK) : 32'd0) + 32'(pos_eff >> 1);
  assign bidx    = 32'(addr_r[9:2]);
  assign bus_ok  = bidx < 32'(STORE_WORDS);

  assign word  = fetch_r ? (fetch_ok_r ? ram_q : 32'd0) : held_r[ch];
  assign pulse = pos_r[ch][0] ? word[31:16] : word[15:0];
  assign divv  = (s[15:8] == 8'd0) ? 9'd256 : {1'b0, s[15:8]};
  assign cdiv  = {1'b0, clk_setup_r[11:4]} + 9'd1;

  // minimum pulse width check, in half-nanosecond units
  assign t25   = (39'(cycles_r) << 4) + (39'(cycles_r) << 3) + 39'(cycles_r);
  assign twons = (src == 2'd1) ? t25 : (t25 << 1);
  assign min_t = MIN_BASE + ((src == 2'd1) ? 17'(MIN_FAST * 17'(cdiv)) :
                                             17'(MIN_SLOW * 17'(cdiv)));
  assign too_short = twons <= 39'(min_t);
  assign sent_inc  = sent_r[ch] + 9'd1;

  ptt_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_ram (
    .clk   (clk),
    .we    (cmd.exec && (op_r == OP_RAM_WR) && bus_ok),
    .waddr (bidx[AW-1:0]),
    .wdata (data_r),
    .raddr (cmd.achk ? fidx[AW-1:0] : bidx[AW-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    case (addr_r)
      REG_SETUP0:  reg_rd = 32'(setup_r[0]);
      REG_SETUP1:  reg_rd = 32'(setup_r[1]);
      REG_ADDR0:   reg_rd = 32'(pos_r[0] >> 1);
      REG_ADDR1:   reg_rd = 32'(WORDS_PER_BLOCK) + 32'(pos_r[1] >> 1);
      REG_IRQ_RAW: reg_rd = 32'(irq_raw_r);
      REG_IRQ_MSK: reg_rd = 32'(irq_raw_r & irq_en_r);
      REG_IRQ_EN:  reg_rd = 32'(irq_en_r);
      REG_CARR0:   reg_rd = carrier_r[0];
      REG_CARR1:   reg_rd = carrier_r[1];
      REG_THR0:    reg_rd = 32'(thr_r[0]);
      REG_THR1:    reg_rd = 32'(thr_r[1]);
      REG_CLOCK:   reg_rd = clk_setup_r;
      default:     reg_rd = 32'd0;
    endcase
  end

  always_comb begin
    sts.op        = op_r;
    sts.wr_ch     = wr_ch;
    sts.start_ok  = start_pend_r && !bad && !overlap;
    sts.tick_adv  = busy_r[ch] && (cyc_r[ch] <= 32'd1);
    sts.achk_stop = at_end && !s[4];
    sts.ard_stop  = pulse[14:0] == 15'd0;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      addr_r <= in_addr;
      data_r <= in_data;
      rd_r   <= 32'd0;
    end
    if (cmd.exec && (op_r == OP_REG_RD)) begin
      rd_r <= reg_rd;
    end
    if (cmd.ramrd) begin
      rd_r <= bus_ok ? ram_q : 32'd0;
    end
    if (cmd.achk) begin
      fetch_r    <= !pos_eff[0];
      fetch_ok_r <= fidx < 32'(STORE_WORDS);
    end
    if (cmd.ard) begin
      if (fetch_r) begin
        held_r[ch] <= word;
      end
      pulse_r <= pulse;
      prod1_r <= 24'(pulse[14:0]) * 24'(divv);
    end
    if (cmd.amul) begin
      cycles_r <= 33'(prod1_r) * 33'(cdiv);
    end
    if (cmd.finish) begin
      result_r <= {faults_r, en_v, lv_v, |(irq_raw_r & irq_en_r), rd_r};
    end
  end

  assign lv_v   = {lvl_r[1], lvl_r[0]};
  assign en_v   = {en_r[1], en_r[0]};
  assign result = result_r;

  // channel and register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_setup_r  <= CLOCK_RST;
      irq_raw_r    <= '0;
      irq_en_r     <= '0;
      faults_r     <= '0;
      start_pend_r <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        setup_r[i]     <= SETUP_RST;
        app_setup_r[i] <= SETUP_RST;
        thr_r[i]       <= THR_RST;
        app_thr_r[i]   <= THR_RST;
        pos_r[i]       <= '0;
        sent_r[i]      <= '0;
        busy_r[i]      <= 1'b0;
        cyc_r[i]       <= '0;
        carrier_r[i]   <= '0;
        lvl_r[i]       <= 1'b0;
        en_r[i]        <= 1'b0;
      end
    end else begin
      if (cmd.latch) begin
        faults_r     <= '0;
        start_pend_r <= 1'b0;
      end

      if (cmd.exec && (op_r == OP_REG_WR)) begin
        case (addr_r)
          REG_SETUP0, REG_SETUP1: begin
            setup_r[wr_ch] <= new_s;
            if (data_r[24]) begin
              app_setup_r[wr_ch] <= new_s;
              app_thr_r[wr_ch]   <= thr_r[wr_ch];
            end
            busy_r[wr_ch] <= busy_a && !data_r[0];
            if (!busy_a || data_r[0]) begin
              cyc_r[wr_ch] <= '0;
            end
            if (data_r[0] && busy_a) begin
              lvl_r[wr_ch] <= 1'b0;
              en_r[wr_ch]  <= 1'b0;
            end else if (data_r[24] && !busy_a) begin
              lvl_r[wr_ch] <= new_s[5];
              en_r[wr_ch]  <= new_s[6];
            end
            if (data_r[1] && !busy_a) begin
              pos_r[wr_ch] <= '0;
            end
            if (fault_any) begin
              faults_r[wr_ch] <= 1'b1;
            end
            start_pend_r <= data_r[0] && !busy_a;
          end
          REG_IRQ_EN:  irq_en_r  <= data_r[13:0];
          REG_IRQ_CLR: irq_raw_r <= irq_raw_r & ~data_r[13:0];
          REG_CARR0, REG_CARR1: carrier_r[wr_ch] <= data_r;
          REG_THR0, REG_THR1:   thr_r[wr_ch]     <= data_r[19:0];
          REG_CLOCK: begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
              if (busy_r[i] && (clk_setup_r != data_r)) begin
                busy_r[i]   <= 1'b0;
                cyc_r[i]    <= '0;
                lvl_r[i]    <= 1'b0;
                en_r[i]     <= 1'b0;
                faults_r[i] <= 1'b1;
              end
            end
            clk_setup_r <= data_r & CLOCK_MASK;
          end
          default: ;
        endcase
      end

      if (cmd.start && start_pend_r) begin
        if (bad || overlap) begin
          busy_r[ch]   <= 1'b0;
          cyc_r[ch]    <= '0;
          lvl_r[ch]    <= 1'b0;
          en_r[ch]     <= 1'b0;
          faults_r[ch] <= 1'b1;
          if (!bad) begin
            busy_r[oc]   <= 1'b0;
            cyc_r[oc]    <= '0;
            lvl_r[oc]    <= 1'b0;
            en_r[oc]     <= 1'b0;
            faults_r[oc] <= 1'b1;
          end
        end else begin
          pos_r[ch]  <= '0;
          sent_r[ch] <= '0;
          busy_r[ch] <= 1'b1;
        end
      end

      if (cmd.tick && busy_r[ch]) begin
        if (cyc_r[ch] > 32'd1) begin
          cyc_r[ch] <= cyc_r[ch] - 32'd1;
        end else begin
          cyc_r[ch] <= '0;
          if ((pos_r[ch] != '0) && !pos_r[ch][0] && (lim != '0) && (sent_r[ch] == '0)) begin
            irq_raw_r[8 + 32'(ch)] <= 1'b1;
          end
        end
      end

      if (cmd.achk) begin
        if (at_end && !s[4]) begin
          // end of blocks without wrap: stop with end interrupt
          busy_r[ch] <= 1'b0;
          cyc_r[ch]  <= '0;
          lvl_r[ch]  <= s[6] ? s[5] : 1'b0;
          en_r[ch]   <= 1'b1;
          irq_raw_r[4 + 32'(ch)] <= 1'b1;
        end else begin
          pos_r[ch] <= pos_eff;
        end
      end

      if (cmd.ard && (pulse[14:0] == 15'd0)) begin
        // zero count terminates the train
        busy_r[ch] <= 1'b0;
        cyc_r[ch]  <= '0;
        lvl_r[ch]  <= s[6] ? s[5] : pulse[15];
        en_r[ch]   <= 1'b1;
        irq_raw_r[32'(ch)] <= 1'b1;
      end

      if (cmd.afin) begin
        if (too_short) begin
          busy_r[ch]   <= 1'b0;
          cyc_r[ch]    <= '0;
          lvl_r[ch]    <= 1'b0;
          en_r[ch]     <= 1'b0;
          faults_r[ch] <= 1'b1;
        end else begin
          lvl_r[ch] <= pulse_r[15];
          en_r[ch]  <= 1'b1;
          pos_r[ch] <= pos_inc;
          if (!pos_inc[0] && (lim != '0)) begin
            sent_r[ch] <= (sent_inc == lim) ? 9'd0 : sent_inc;
          end
          cyc_r[ch] <= cycles_r[31:0];
        end
      end
    end
  end

endmodule

>>> src/ptt_ctrl.sv
// Controller FSM: sequences bus accesses, starts and per-channel tick work.
// Depends on ptt_pkg and assert_macros.svh; commands ptt_datapath.
`include "assert_macros.svh"

module ptt_ctrl import ptt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   ch_r, ch_nxt;
  logic   out_valid_r;

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.ch    = ch_r;
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          OP_RAM_RD: state_nxt = ST_RAMRD;
          OP_REG_WR: begin
            state_nxt = ST_START;
            ch_nxt    = sts.wr_ch;
          end
          OP_TICK: begin
            state_nxt = ST_TICK;
            ch_nxt    = 1'b0;
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_RAMRD: begin
        cmd.ramrd = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = sts.start_ok ? ST_ACHK : ST_FIN;
      end
      ST_TICK: begin
        cmd.tick = 1'b1;
        if (sts.tick_adv) begin
          state_nxt = ST_ACHK;
        end else if (!ch_r) begin
          ch_nxt = 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_ACHK: begin
        cmd.achk = 1'b1;
        if (!sts.achk_stop) begin
          state_nxt = ST_ARD;
        end else if ((sts.op == OP_TICK) && !ch_r) begin
          state_nxt = ST_TICK;
          ch_nxt    = 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_ARD: begin
        cmd.ard = 1'b1;
        if (!sts.ard_stop) begin
          state_nxt = ST_AMUL;
        end else if ((sts.op == OP_TICK) && !ch_r) begin
          state_nxt = ST_TICK;
          ch_nxt    = 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_AMUL: begin
        cmd.amul  = 1'b1;
        state_nxt = ST_AFIN;
      end
      ST_AFIN: begin
        cmd.afin = 1'b1;
        if ((sts.op == OP_TICK) && !ch_r) begin
          state_nxt = ST_TICK;
          ch_nxt    = 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `PTT_ASSERT(a_accept_exec, (in_tvalid && in_tready) |=> (state_r == ST_EXEC), "accept did not enter exec")
  `PTT_ASSERT(a_fin_result, (state_r == ST_FIN && (!out_valid_r || out_tready)) |=> out_valid_r, "result not presented")
  `PTT_ASSERT(a_afin_next, (state_r == ST_AFIN) |=> (state_r == ST_TICK || state_r == ST_FIN), "bad state after pulse load")

endmodule

>>> src/pulse_train_transmitter.sv
// Top level of the two-channel pulse train transmitter.
// Depends on ptt_pkg, ptt_ctrl, ptt_datapath (which holds ptt_ram).
//
// Usage:
//  - Input channel in_*: one beat is one bus access or one source-clock tick.
//    in_tuser carries the opcode; in_tdata carries address and write data.
//  - Output channel out_*: exactly one result beat per input beat, in order,
//    with read data, interrupt line, line levels/enables and fault mask.
//  - Items are handled one at a time by a controller FSM. From accept to
//    result beat, a register read or RAM write passes execute and finish
//    steps; a RAM read adds a read step, a register write a start step, a
//    setup write that starts a channel also a 4-step fetch/multiply pass
//    (RAM read, count x divider, x clock divider, width check), and a tick a
//    tick step per channel plus that pass for each channel ending a pulse.
//    The next beat is accepted on the edge where the result can first leave.
//  - The next item is accepted while a finished result still waits in the
//    output register; a receiver stall only holds the FSM at its last step.
//  - Reset (rst_n low, synchronous) returns control, register and channel state
//    to reset values and idles both channels; symbol RAM contents are not cleared.
module pulse_train_transmitter import ptt_pkg::*; #(
  parameter int WORDS_PER_BLOCK = WPB_DEFAULT,
  parameter int STORE_WORDS     = STORE_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] address, [41:10] write_data
  input  logic [2:0]             in_tuser,   // [2:0] opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] read_data, [32] irq_line,
                                             // [34:33] line_levels,
                                             // [36:35] line_enables, [38:37] fault_mask
);

  cmd_t cmd;
  sts_t sts;
  logic [RESULT_W-1:0] result;

  ptt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ptt_datapath #(
    .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
    .STORE_WORDS     (STORE_WORDS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_op   (in_tuser),
    .in_addr (in_tdata[9:0]),
    .in_data (in_tdata[41:10]),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

  // pad to whole bytes
  assign out_tdata = {1'b0, result};

endmodule

>>> bench/tb_top.sv
// Self-checking bench for pulse_train_transmitter: stream driver, monitor and a
// cycle-free predictor of the register, symbol RAM and channel behavior.
// Depends on ptt_pkg and the RTL of pulse_train_transmitter only.
module tb_top import ptt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WPB  = WPB_DEFAULT;
  localparam int SWDS = STORE_DEFAULT;
  localparam int WATCHDOG_CYCLES = 4000;

  typedef struct packed {
    logic        sync;   // hold the sender until every result is back
    logic [2:0]  op;
    logic [9:0]  addr;
    logic [31:0] data;
  } bus_item_t;

  // packed from the top down, so read_data lands in the low bits
  typedef struct packed {
    logic [1:0]  flt;
    logic [1:0]  en;
    logic [1:0]  lv;
    logic        irq;
    logic [31:0] rd;
  } line_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  always #4 clk = ~clk;

  pulse_train_transmitter uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  bus_item_t   stim_q[$];
  line_state_t want_q[$];
  bit stim_built = 0;
  int fail_cnt = 0;
  int results_seen = 0;

  // ---------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------
  logic [31:0] clk_cfg, irq_raw, irq_ena;
  logic [31:0] ch_cfg[2], ch_cfg_live[2], ch_thr[2], ch_thr_live[2];
  logic [31:0] ch_pos[2], ch_sent[2], ch_word[2], ch_left[2], carrier[2];
  logic        ch_run[2], lvl[2], ena[2];
  logic [31:0] sym_ram[SWDS];
  logic [1:0]  step_flt;

  function void pm_reset();
    clk_cfg = CLOCK_RST;
    irq_raw = 0;
    irq_ena = 0;
    for (int i = 0; i < 2; i++) begin
      ch_cfg[i] = SETUP_RST;
      ch_cfg_live[i] = SETUP_RST;
      ch_thr[i] = THR_RST;
      ch_thr_live[i] = THR_RST;
      ch_pos[i] = 0;
      ch_sent[i] = 0;
      ch_word[i] = 0;
      ch_left[i] = 0;
      carrier[i] = 0;
      ch_run[i] = 0;
      lvl[i] = 0;
      ena[i] = 0;
    end
  endfunction

  function void set_line(int ch, logic l, logic e);
    lvl[ch] = l;
    ena[ch] = e;
  endfunction

  function void ch_halt(int ch, logic marker);
    ch_run[ch] = 0;
    ch_left[ch] = 0;
    set_line(ch, ch_cfg_live[ch][6] ? ch_cfg_live[ch][5] : marker, 1'b1);
  endfunction

  function void ch_fault(int ch);
    ch_run[ch] = 0;
    ch_left[ch] = 0;
    set_line(ch, 1'b0, 1'b0);
    step_flt[ch] = 1'b1;
  endfunction

  // fetch the next pulse, check its width and load its duration
  function void ch_next_pulse(int ch);
    logic [31:0] s, p, idx, lim;
    logic [15:0] pulse;
    longint unsigned cnt, dv, cdv, cyc, twons, floor_ns;
    if (!ch_run[ch]) return;
    s = ch_cfg_live[ch];
    p = ch_pos[ch];
    if (p >= s[18:16] * WPB * 2) begin
      if (s[4]) p = 0;
      else begin
        ch_pos[ch] = p;
        ch_halt(ch, 1'b0);
        irq_raw[4+ch] = 1'b1;
        return;
      end
    end
    if (!p[0]) begin
      idx = ch * WPB + p / 2;
      ch_word[ch] = (idx < SWDS) ? sym_ram[idx] : 32'd0;
    end
    ch_pos[ch] = p;
    pulse = p[0] ? ch_word[ch][31:16] : ch_word[ch][15:0];
    cnt = pulse[14:0];
    if (cnt == 0) begin
      ch_halt(ch, pulse[15]);
      irq_raw[ch] = 1'b1;
      return;
    end
    dv = (s[15:8] == 0) ? 256 : s[15:8];
    cdv = clk_cfg[11:4] + 1;
    cyc = cnt * dv * cdv;
    twons = cyc * ((clk_cfg[25:24] == 1) ? 25 : 50);
    floor_ns = 125 + ((clk_cfg[25:24] == 1) ? 150 : 300) * cdv;
    if (twons <= floor_ns) begin
      ch_fault(ch);
      return;
    end
    set_line(ch, pulse[15], 1'b1);
    p = p + 1;
    ch_pos[ch] = p;
    if (!p[0]) begin
      lim = ch_thr_live[ch] & 32'h1ff;
      if (lim != 0) begin
        ch_sent[ch] = (ch_sent[ch] + 1) & 32'h1ff;
        if (ch_sent[ch] == lim) ch_sent[ch] = 0;
      end
    end
    ch_left[ch] = cyc[31:0];
  endfunction

  function void ch_start(int ch);
    logic [31:0] s;
    logic [2:0] blk;
    logic [1:0] src;
    logic bad;
    s = ch_cfg_live[ch];
    blk = s[18:16];
    src = clk_cfg[25:24];
    bad = (blk == 0) || (blk > 4 - ch) || ((s & 32'h200008) != 0) || ch_thr_live[ch][19] ||
          !clk_cfg[26] || !clk_cfg[0] || ((clk_cfg & CLOCK_BAD) != 0) ||
          (src != 1 && src != 3);
    if (bad) begin
      ch_fault(ch);
      return;
    end
    // the two channels may not claim the same RAM blocks
    if (ch_run[1-ch] && ((ch == 0 && blk > 1) || (ch == 1 && ch_cfg_live[0][18:16] > 1))) begin
      ch_fault(ch);
      ch_fault(1 - ch);
      return;
    end
    ch_pos[ch] = 0;
    ch_sent[ch] = 0;
    ch_run[ch] = 1;
    ch_next_pulse(ch);
  endfunction

  function logic [31:0] pm_reg_get(logic [9:0] a);
    case (a)
      REG_SETUP0, REG_SETUP1:   return ch_cfg[a[2]];
      REG_ADDR0, REG_ADDR1:     return a[2] * WPB + ch_pos[a[2]] / 2;
      REG_IRQ_RAW:              return irq_raw;
      REG_IRQ_MSK:              return irq_raw & irq_ena;
      REG_IRQ_EN:               return irq_ena;
      REG_CARR0, REG_CARR1:     return carrier[a[2]];
      REG_THR0, REG_THR1:       return ch_thr[a[2]];
      REG_CLOCK:                return clk_cfg;
      default:                  return 32'd0;
    endcase
  endfunction

  function void pm_reg_put(logic [9:0] a, logic [31:0] v);
    int ch;
    ch = a[2];
    case (a)
      REG_SETUP0, REG_SETUP1: begin
        ch_cfg[ch] = v & 32'h7fff78;
        if (v[24]) begin
          if (ch_run[ch] && ch_cfg_live[ch] != ch_cfg[ch] && !v[7]) ch_fault(ch);
          ch_cfg_live[ch] = ch_cfg[ch];
          ch_thr_live[ch] = ch_thr[ch];
          if (v[7]) ch_halt(ch, 1'b0);
          if (!ch_run[ch]) set_line(ch, ch_cfg_live[ch][5], ch_cfg_live[ch][6]);
        end
        if (v[1] && !ch_run[ch]) ch_pos[ch] = 0;
        if (v[0]) begin
          if (ch_run[ch]) ch_fault(ch);
          else ch_start(ch);
        end
      end
      REG_IRQ_EN:           irq_ena = v & 32'h3fff;
      REG_IRQ_CLR:          irq_raw = irq_raw & ~v & 32'h3fff;
      REG_CARR0, REG_CARR1: carrier[ch] = v;
      REG_THR0, REG_THR1:   ch_thr[ch] = v & 32'hfffff;
      REG_CLOCK: begin
        for (int i = 0; i < 2; i++)
          if (ch_run[i] && clk_cfg != v) ch_fault(i);
        clk_cfg = v & CLOCK_MASK;
      end
      default: ;
    endcase
  endfunction

  function line_state_t bus_step(logic [2:0] op, logic [9:0] a, logic [31:0] d);
    line_state_t r;
    r = '0;
    step_flt = 0;
    case (op)
      OP_REG_RD: r.rd = pm_reg_get(a);
      OP_REG_WR: pm_reg_put(a, d);
      OP_RAM_RD: r.rd = (a[9:2] < SWDS) ? sym_ram[a[9:2]] : 32'd0;
      OP_RAM_WR: if (a[9:2] < SWDS) sym_ram[a[9:2]] = d;
      OP_TICK: begin
        // channel 0 is served first
        for (int i = 0; i < 2; i++) begin
          if (!ch_run[i]) continue;
          if (ch_left[i] > 1) ch_left[i]--;
          else begin
            ch_left[i] = 0;
            if (ch_pos[i] != 0 && !ch_pos[i][0] && (ch_thr_live[i] & 32'h1ff) != 0 &&
                ch_sent[i] == 0)
              irq_raw[8+i] = 1'b1;
            ch_next_pulse(i);
          end
        end
      end
      default: ;
    endcase
    r.irq = (irq_raw & irq_ena) != 0;
    r.lv = {lvl[1], lvl[0]};
    r.en = {ena[1], ena[0]};
    r.flt = step_flt;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------
  logic [9:0] reg_addrs[15] = '{REG_SETUP0, REG_SETUP1, REG_ADDR0, REG_ADDR1, REG_IRQ_RAW,
                                REG_IRQ_MSK, REG_IRQ_EN, REG_IRQ_CLR, REG_CARR0, REG_CARR1,
                                REG_THR0, REG_THR1, REG_CLOCK, 10'h064, 10'h070};

  task automatic add(logic [2:0] op, logic [9:0] a, logic [31:0] d);
    stim_q.push_back('{sync: 1'b0, op: op, addr: a, data: d});
  endtask

  task automatic add_sync();
    stim_q.push_back('{sync: 1'b1, op: OP_TICK, addr: '0, data: '0});
  endtask

  // mostly legal widths, a few train ends, a few too-short pulses
  function automatic logic [15:0] rand_pulse();
    logic [14:0] c;
    int k;
    k = $urandom_range(0, 19);
    if (k < 2) c = 0;
    else if (k == 2) c = $urandom_range(1, 6);
    else c = $urandom_range(12, 25);
    return {1'($urandom), c};
  endfunction

  function automatic logic [31:0] good_clock();
    return 32'h04000001 | ({30'd0, ($urandom_range(0, 1) ? 2'd1 : 2'd3)} << 24) |
           ({31'd0, 1'($urandom)} << 31) | ({31'd0, 1'($urandom)} << 3) |
           ({31'd0, 1'($urandom)} << 1) | (32'($urandom_range(0, 1)) << 4);
  endfunction

  task automatic add_reads(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) add(OP_RAM_RD, 10'($urandom_range(0, SWDS - 1)) << 2, '0);
      else add(OP_REG_RD, reg_addrs[$urandom_range(0, 14)], '0);
    end
  endtask

  // one pulse-train session: set up clock, threshold and a channel, then tick
  task automatic add_train();
    int ch, blk, ticks;
    logic [31:0] setup_w;
    ch = $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) add(OP_REG_WR, REG_CLOCK, good_clock());
    if ($urandom_range(0, 1)) add(OP_REG_WR, ch ? REG_THR1 : REG_THR0,
                                  ($urandom_range(0, 15) == 0) ? 32'h80000 | $urandom_range(0, 6)
                                                               : $urandom_range(0, 6));
    if ($urandom_range(0, 3) == 0) add(OP_REG_WR, REG_IRQ_EN, $urandom);
    blk = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 1;
    setup_w = 32'h01000001 | (32'(blk) << 16) | (32'($urandom_range(1, 3)) << 8) |
              (32'($urandom_range(0, 7)) << 4) | ($urandom_range(0, 1) ? 32'h2 : 32'h0);
    if ($urandom_range(0, 12) == 0) setup_w |= 32'h8;
    if ($urandom_range(0, 12) == 0) setup_w |= 32'h200000;
    add(OP_REG_WR, ch ? REG_SETUP1 : REG_SETUP0, setup_w);
    ticks = $urandom_range(20, 90);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 7) == 0) add_reads(1);
      else if ($urandom_range(0, 40) == 0) add(OP_REG_WR, REG_IRQ_CLR, $urandom);
      else if ($urandom_range(0, 60) == 0)
        add(OP_RAM_WR, 10'($urandom_range(0, SWDS - 1)) << 2, {rand_pulse(), rand_pulse()});
      else add(OP_TICK, 10'($urandom), $urandom);
    end
    if ($urandom_range(0, 2) == 0)
      add(OP_REG_WR, ch ? REG_SETUP1 : REG_SETUP0, 32'h01000080 | ($urandom & 32'h007fff78));
  endtask

  task automatic build_stimulus();
    int rnd_items;
    // every symbol word gets written so no fetch or read finds an unwritten entry
    for (int i = 0; i < SWDS; i++) add(OP_RAM_WR, 10'(i << 2), {rand_pulse(), rand_pulse()});

    // directed: reset values, idle codes, odd addresses, start and clock faults
    add(OP_REG_RD, REG_SETUP0, '0);
    add(OP_REG_RD, REG_CLOCK, '0);
    add(OP_REG_RD, 10'h011, '0);
    add(OP_REG_WR, 10'h064, 32'hffffffff);
    add(3'd5, 10'h3ff, 32'hffffffff);
    add(3'd7, 10'h000, 32'h00000000);
    add(OP_RAM_WR, 10'h3ff, 32'hffffffff);
    add(OP_RAM_RD, 10'h3fc, '0);
    add(OP_REG_WR, REG_CARR1, 32'hffffffff);
    add(OP_REG_WR, REG_IRQ_EN, 32'hffffffff);
    add(OP_REG_WR, REG_SETUP0, 32'h01010101);   // clock not enabled: fault
    add(OP_REG_WR, REG_CLOCK, 32'h05000001);
    add(OP_REG_WR, REG_SETUP0, 32'h01010101);   // runs
    add(OP_REG_WR, REG_SETUP1, 32'h01010101);   // runs beside channel 0
    add(OP_REG_WR, REG_SETUP0, 32'h00000001);   // start while busy
    add(OP_REG_WR, REG_CLOCK, 32'h07000011);    // clock change while busy
    add(OP_REG_WR, REG_CLOCK, 32'h05000001);
    add(OP_REG_WR, REG_SETUP1, 32'h01010101);
    add(OP_REG_WR, REG_SETUP0, 32'h01020101);   // overlaps channel 1 RAM
    add(OP_REG_WR, REG_SETUP0, 32'h01010109);   // reserved setup bit
    add(OP_REG_WR, REG_SETUP0, 32'h01000101);   // zero blocks
    add(OP_REG_WR, REG_SETUP1, 32'h01040101);   // too many blocks
    add(OP_REG_WR, REG_THR0, 32'hffffffff);
    add(OP_REG_WR, REG_SETUP0, 32'h01010101);   // threshold bit 19
    add(OP_REG_WR, REG_THR0, 32'h00000002);
    add(OP_REG_WR, REG_SETUP0, 32'h01010101);
    add(OP_REG_WR, REG_SETUP0, 32'h010101e0);   // stop with idle level and enable
    add(OP_REG_WR, REG_SETUP0, 32'h00000002);   // rewind
    add(OP_REG_RD, REG_IRQ_RAW, '0);
    add(OP_REG_WR, REG_IRQ_CLR, 32'hffffffff);
    add_sync();

    // run channel 0 to the end of its block without wrap; the slow source clock
    // allows the shortest legal pulse count
    add(OP_REG_WR, REG_SETUP1, 32'h01000080);
    add(OP_REG_WR, REG_CLOCK, 32'h07000001);
    add(OP_REG_WR, REG_THR0, 32'd3);
    for (int i = 0; i < WPB; i++) add(OP_RAM_WR, 10'(i << 2), 32'h00098009);
    add(OP_REG_WR, REG_SETUP0, 32'h01010101);
    for (int i = 0; i < WPB * 2 * 9 + 4; i++) begin
      if (i % 97 == 0) add(OP_REG_RD, REG_ADDR0, '0);
      add(OP_TICK, '0, '0);
    end
    add(OP_REG_RD, REG_IRQ_RAW, '0);
    add_sync();

    // random part: mostly sessions, some raw noise
    rnd_items = 0;
    while (rnd_items < 150) begin
      int before_n;
      before_n = stim_q.size();
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < 8; i++) add(3'($urandom), 10'($urandom), $urandom);
      end else add_train();
      rnd_items += stim_q.size() - before_n;
    end
    stim_built = 1;
  endtask

  // ---------------------------------------------------------------------
  // Input side: prediction on accept, driver at the falling edge
  // ---------------------------------------------------------------------
  logic in_fire = 1'b0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit long_hold_done = 0;
  bit quiet;

  assign quiet = stim_built && stim_q.size() < 150;

  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      want_q.push_back(bus_step(in_tuser, in_tdata[9:0], in_tdata[41:10]));
  end

  always @(negedge clk) begin
    bus_item_t nx;
    logic v;
    v = in_tvalid;
    if (in_tvalid && in_fire) v = 1'b0;
    if (rst_n && !v) begin
      if (gap_left > 0) gap_left--;
      else if (stim_q.size() > 0) begin
        if (stim_q[0].sync) begin
          if (want_q.size() == 0) void'(stim_q.pop_front());
        end else begin
          nx = stim_q.pop_front();
          v = 1'b1;
          in_tuser <= nx.op;
          in_tdata <= {6'd0, nx.data, nx.addr};
          if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 10);
        end
      end
    end
    in_tvalid <= v;
  end

  // ---------------------------------------------------------------------
  // Output side: receiver stalls, one long hold-off, compare at rising edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic r;
    r = 1'b0;
    if (!rst_n) r = 1'b0;
    else if (hold_left > 0) hold_left--;
    else if (!long_hold_done && results_seen >= 300) begin
      // long hold-off so the block backs up into its input
      long_hold_done = 1;
      hold_left = 400;
    end else if (stall_left > 0) stall_left--;
    else begin
      r = 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
    end
    out_tready <= r;
  end

  always @(posedge clk) begin
    line_state_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = out_tdata[RESULT_W-1:0];
      if (want_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        fail_cnt++;
      end else begin
        exp_r = want_q.pop_front();
        if (got.rd !== exp_r.rd) begin
          $error("read_data exp %h got %h", exp_r.rd, got.rd); fail_cnt++;
        end
        if (got.irq !== exp_r.irq) begin
          $error("irq_line exp %b got %b", exp_r.irq, got.irq); fail_cnt++;
        end
        if (got.lv !== exp_r.lv) begin
          $error("line_levels exp %b got %b", exp_r.lv, got.lv); fail_cnt++;
        end
        if (got.en !== exp_r.en) begin
          $error("line_enables exp %b got %b", exp_r.en, got.en); fail_cnt++;
        end
        if (got.flt !== exp_r.flt) begin
          $error("fault_mask exp %b got %b", exp_r.flt, got.flt); fail_cnt++;
        end
      end
    end
  end

  // watchdog: no beat on either side for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    pm_reset();
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() > 0 || in_tvalid || want_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_cnt == 0 && want_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
